// ----- hdl/hmq_pkg.sv -----
// ============================================================================
// hmq_pkg: shared types for the binary min-heap queue
// Controller states, result status codes and controller/datapath interface.
// ============================================================================
package hmq_pkg;

    // Result status of one transaction
    typedef enum logic [1:0] {
        HQ_DONE  = 2'd0,
        HQ_FULL  = 2'd1,
        HQ_EMPTY = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_POP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic    load;        // latch the incoming transaction
        logic    set_status;  // record a rejection code
        t_status status_code;
        logic    start_ins;   // hole at the end, bump count
        logic    rd_up;       // read parent of hole
        logic    step_up;     // move parent down into hole
        logic    rd_pop;      // read root and last entry
        logic    take_pop;    // capture root, last entry becomes mover
        logic    rd_down;     // read both children of hole
        logic    step_down;   // move smaller child up into hole
        logic    put_mov;     // park mover in hole
        logic    out_load;    // load result register
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic one_left;
        logic pos_zero;
        logic up_swap;
        logic down_swap;
    } t_dp_stat;

endpackage

// ----- hdl/hmq_dp.sv -----
// ============================================================================
// hmq_dp: heap datapath
// Entry memory, hole position, mover register, key compare and result regs.
// ============================================================================
module hmq_dp #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hmq_pkg::t_dp_cmd              i_cmd,
    output hmq_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_command,
    input  logic [KEY_WIDTH-1:0]          i_new_key,
    input  logic [TAG_WIDTH-1:0]          i_new_tag,
    output logic [KEY_WIDTH-1:0]          o_popped_key,
    output logic [TAG_WIDTH-1:0]          o_popped_tag,
    output logic [1:0]                    o_status,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);
    import hmq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = AW + 2;
    localparam int EW = KEY_WIDTH + TAG_WIDTH;

    logic [EW-1:0]        mem [CAPACITY];
    logic [EW-1:0]        r_rd_a, r_rd_b;
    logic [EW-1:0]        r_mov;
    logic [AW-1:0]        r_pos;
    logic [IW-1:0]        r_count;
    logic                 r_key_signed;
    logic                 r_is_remove;
    t_status              r_status;
    logic [KEY_WIDTH-1:0] r_pop_key;
    logic [TAG_WIDTH-1:0] r_pop_tag;
    logic [KEY_WIDTH-1:0] r_out_key;
    logic [TAG_WIDTH-1:0] r_out_tag;
    t_status              r_out_status;
    logic [IW-1:0]        r_out_count;

    logic [AW-1:0]        addr_a, addr_b, wr_addr, parent;
    logic [EW-1:0]        wr_data, chosen;
    logic                 wr_en;
    logic [CW-1:0]        left_idx, right_idx, count_ext, chosen_idx;
    logic                 left_ok, right_ok;
    logic [KEY_WIDTH-1:0] key_a, key_b, key_mov, best_key;

    function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b,
                                      input logic sgn);
        logic [KEY_WIDTH-1:0] m;
        m = '0;
        m[KEY_WIDTH-1] = sgn;
        return (a ^ m) < (b ^ m);
    endfunction

    assign key_a   = r_rd_a[EW-1:TAG_WIDTH];
    assign key_b   = r_rd_b[EW-1:TAG_WIDTH];
    assign key_mov = r_mov[EW-1:TAG_WIDTH];

    assign parent    = (r_pos - AW'(1)) >> 1;
    assign left_idx  = {1'b0, r_pos, 1'b1};
    assign right_idx = left_idx + CW'(1);
    assign count_ext = CW'(r_count);

    // Smallest strictly-smaller child, left wins ties
    always_comb begin
        left_ok    = (left_idx < count_ext) && key_less(key_a, key_mov, r_key_signed);
        best_key   = left_ok ? key_a : key_mov;
        right_ok   = (right_idx < count_ext) && key_less(key_b, best_key, r_key_signed);
        chosen     = right_ok ? r_rd_b : r_rd_a;
        chosen_idx = right_ok ? right_idx : left_idx;
    end

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        priority if (i_cmd.rd_pop) begin
            addr_b = AW'(r_count - IW'(1));
        end else if (i_cmd.rd_up) begin
            addr_a = parent;
        end else if (i_cmd.rd_down) begin
            addr_a = left_idx[AW-1:0];
            addr_b = right_idx[AW-1:0];
        end else begin
            addr_a = '0;
            addr_b = '0;
        end
    end

    always_comb begin
        wr_en   = i_cmd.step_up | i_cmd.step_down | i_cmd.put_mov;
        wr_addr = r_pos;
        priority if (i_cmd.step_up) begin
            wr_data = r_rd_a;
        end else if (i_cmd.step_down) begin
            wr_data = chosen;
        end else begin
            wr_data = r_mov;
        end
    end

    // Entry memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_key_signed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key_signed <= i_cfg_wdata;
            end
            if (i_cmd.start_ins) begin
                r_count <= r_count + IW'(1);
            end else if (i_cmd.take_pop) begin
                r_count <= r_count - IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_remove <= i_command;
            r_mov       <= {i_new_key, i_new_tag};
            r_status    <= HQ_DONE;
            r_pop_key   <= '0;
            r_pop_tag   <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.start_ins) begin
            r_pos <= AW'(r_count);
        end
        if (i_cmd.take_pop) begin
            r_pop_key <= key_a;
            r_pop_tag <= r_rd_a[TAG_WIDTH-1:0];
            r_mov     <= r_rd_b;
            r_pos     <= '0;
        end
        if (i_cmd.step_up) begin
            r_pos <= parent;
        end
        if (i_cmd.step_down) begin
            r_pos <= chosen_idx[AW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_key    <= r_pop_key;
            r_out_tag    <= r_pop_tag;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_stat.is_remove = r_is_remove;
    assign o_stat.full      = (r_count == IW'(CAPACITY));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.one_left  = (r_count == IW'(1));
    assign o_stat.pos_zero  = (r_pos == '0);
    assign o_stat.up_swap   = key_less(key_mov, key_a, r_key_signed);
    assign o_stat.down_swap = left_ok | right_ok;

    assign o_popped_key  = r_out_key;
    assign o_popped_tag  = r_out_tag;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_status == HQ_EMPTY |-> r_count == '0)
        else $error("empty status with entries held");

    a_full_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && r_status == HQ_FULL |-> r_count == IW'(CAPACITY))
        else $error("full status below capacity");

    a_child_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_down |-> chosen_idx < count_ext)
        else $error("sift-down moved a dead slot");

    a_up_nonroot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_up |-> r_pos != '0)
        else $error("parent read at root");

endmodule

// ----- hdl/hmq_ctrl.sv -----
// ============================================================================
// hmq_ctrl: heap controller
// Sequences insert / remove, sift loops and the result register handshake.
// ============================================================================
module hmq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  hmq_pkg::t_dp_stat i_stat,
    output hmq_pkg::t_dp_cmd  o_cmd
);
    import hmq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.is_remove) begin
                    n_state = i_stat.empty ? S_FIN : S_POP;
                end else begin
                    n_state = i_stat.full ? S_FIN : S_UP_RD;
                end
            end
            S_UP_RD:  n_state = i_stat.pos_zero ? S_FIN : S_UP_CMP;
            S_UP_CMP: n_state = i_stat.up_swap ? S_UP_RD : S_FIN;
            S_POP:    n_state = i_stat.one_left ? S_FIN : S_DN_RD;
            S_DN_RD:  n_state = S_DN_CMP;
            S_DN_CMP: n_state = i_stat.down_swap ? S_DN_RD : S_FIN;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECIDE: begin
                if (i_stat.is_remove) begin
                    if (i_stat.empty) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = HQ_EMPTY;
                    end else begin
                        o_cmd.rd_pop = 1'b1;
                    end
                end else begin
                    if (i_stat.full) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = HQ_FULL;
                    end else begin
                        o_cmd.start_ins = 1'b1;
                    end
                end
            end
            S_UP_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.put_mov = 1'b1;
                end else begin
                    o_cmd.rd_up = 1'b1;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_swap) begin
                    o_cmd.step_up = 1'b1;
                end else begin
                    o_cmd.put_mov = 1'b1;
                end
            end
            S_POP:    o_cmd.take_pop = 1'b1;
            S_DN_RD:  o_cmd.rd_down = 1'b1;
            S_DN_CMP: begin
                if (i_stat.down_swap) begin
                    o_cmd.step_down = 1'b1;
                end else begin
                    o_cmd.put_mov = 1'b1;
                end
            end
            S_FIN:    o_cmd.out_load = out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/binary_min_heap_queue.sv -----
// ============================================================================
// binary_min_heap_queue: min-heap priority queue of (key, tag) entries
// Insert sifts the new entry up, remove returns the root and sifts the last
// entry down from the root. Keys compare unsigned or signed per a register.
// ============================================================================
//
//  channel | signals                                   | transfer
//  --------+-------------------------------------------+---------------------
//  in      | i_in_valid/o_in_ready, command, key, tag  | valid & ready
//  out     | o_out_valid/i_out_ready, popped, status   | valid & ready
//  cfg     | i_cfg_we, i_cfg_wdata (key_signed)        | we high, no wait
//
//  The idle state accepts a transaction; the decide state rejects it when
//  full or empty, or starts it. An insert sifts the new entry up until its
//  parent is not larger or it reaches the root; a remove takes the root and
//  sifts the last entry down. Either makes at most log2(CAPACITY) compares.
//  Each level costs a memory read state and a compare/write state on the
//  single-write, dual-read entry memory; that loop sets the rate.
//  One transaction is worked at a time; a new one is taken as soon as the
//  previous result sits in the output register, even if it is not yet taken.
//  A stalled output holds the finishing transaction in its last state.
//  Reset clears the entry count and key_signed; memory contents need none.
// ============================================================================
module binary_min_heap_queue #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32,
    parameter int TAG_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [KEY_WIDTH-1:0]          i_new_key,
    input  logic [TAG_WIDTH-1:0]          i_new_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [KEY_WIDTH-1:0]          o_popped_key,
    output logic [TAG_WIDTH-1:0]          o_popped_tag,
    output logic [1:0]                    o_status,
    output logic [$clog2(CAPACITY+1)-1:0] o_entry_count
);
    import hmq_pkg::*;

    // Command and status between controller and datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Controller: state machine plus output register valid
    hmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: entry memory, hole/mover registers, compares, result payload
    hmq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_command),
        .i_new_key     (i_new_key),
        .i_new_tag     (i_new_tag),
        .o_popped_key  (o_popped_key),
        .o_popped_tag  (o_popped_tag),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

// ----- dv/binary_min_heap_queue_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// binary_min_heap_queue_tb: self-checking bench for the min-heap queue
// Drives insert/remove transactions with random idling on both channels,
// predicts every result with a behavioral heap and compares field by field.
// ============================================================================
module binary_min_heap_queue_tb;
    import hmq_pkg::*;

    localparam int CAPACITY  = 256;
    localparam int KEY_WIDTH = 32;
    localparam int TAG_WIDTH = 16;
    localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

    // command encoding on i_command
    localparam bit CMD_INSERT = 1'b0;
    localparam bit CMD_REMOVE = 1'b1;

    localparam int IDLE_PCT    = 28;      // percent chance of idling, each side
    localparam int TAIL_CYCLES = 40;      // longer than the slowest transaction
    localparam int DRAIN_LIMIT = 200000;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_WIDTH-1:0] tag;
        t_status              status;
        logic [CNT_WIDTH-1:0] count;
    } t_heap_result;

    // One row of the directed table: a register write or a transaction,
    // optionally with its result typed in.
    typedef struct {
        bit                   is_cfg;
        bit                   cmd;
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_WIDTH-1:0] tag;
        bit                   typed;
        t_heap_result         want;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic                 cfg_wdata   = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_command  = 1'b0;
    logic [KEY_WIDTH-1:0] in_key      = '0;
    logic [TAG_WIDTH-1:0] in_tag      = '0;
    logic                 out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [KEY_WIDTH-1:0] o_popped_key;
    logic [TAG_WIDTH-1:0] o_popped_tag;
    logic [1:0]           o_status;
    logic [CNT_WIDTH-1:0] o_entry_count;

    // Behavioral heap: mirrors the DUT's array layout exactly, since tie
    // handling makes the pop order depend on it.
    logic [KEY_WIDTH-1:0] heap_key [CAPACITY];
    logic [TAG_WIDTH-1:0] heap_tag [CAPACITY];
    int                   heap_count  = 0;
    bit                   heap_signed = 1'b0;

    t_heap_result pending_results[$];
    int           error_count = 0;
    bit           long_burst  = 1'b0;   // no idling on either side while set

    binary_min_heap_queue #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (in_command),
        .i_new_key     (in_key),
        .i_new_tag     (in_tag),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_popped_key  (o_popped_key),
        .o_popped_tag  (o_popped_tag),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit key_before(input logic [KEY_WIDTH-1:0] a,
                                      input logic [KEY_WIDTH-1:0] b);
        if (heap_signed) begin
            return $signed(a) < $signed(b);
        end
        return a < b;
    endfunction

    // Applies one transaction to the heap and returns its result. Sifting
    // moves a hole instead of swapping, which lands entries identically.
    function automatic t_heap_result heap_apply(input bit cmd,
                                                input logic [KEY_WIDTH-1:0] key,
                                                input logic [TAG_WIDTH-1:0] tag);
        t_heap_result         res;
        int                   pos;
        int                   parent;
        int                   best;
        int                   left;
        logic [KEY_WIDTH-1:0] mov_key;
        logic [TAG_WIDTH-1:0] mov_tag;
        logic [KEY_WIDTH-1:0] best_key;
        bit                   done;
        res        = '0;
        res.status = HQ_DONE;
        if (cmd == CMD_INSERT) begin
            if (heap_count >= CAPACITY) begin
                res.status = HQ_FULL;
            end else begin
                pos = heap_count;
                heap_count++;
                // strictly greater parent moves down; equal keys stay put
                while (pos > 0 && key_before(key, heap_key[(pos - 1) / 2])) begin
                    parent        = (pos - 1) / 2;
                    heap_key[pos] = heap_key[parent];
                    heap_tag[pos] = heap_tag[parent];
                    pos           = parent;
                end
                heap_key[pos] = key;
                heap_tag[pos] = tag;
            end
        end else if (heap_count == 0) begin
            res.status = HQ_EMPTY;
        end else begin
            res.key = heap_key[0];
            res.tag = heap_tag[0];
            heap_count--;
            mov_key = heap_key[heap_count];
            mov_tag = heap_tag[heap_count];
            pos     = 0;
            done    = 1'b0;
            while (!done) begin
                best     = pos;
                best_key = mov_key;
                left     = 2 * pos + 1;
                // left child first; right only wins when strictly smaller
                if (left < heap_count && key_before(heap_key[left], best_key)) begin
                    best     = left;
                    best_key = heap_key[left];
                end
                if (left + 1 < heap_count && key_before(heap_key[left + 1], best_key)) begin
                    best = left + 1;
                end
                if (best == pos) begin
                    done = 1'b1;
                end else begin
                    heap_key[pos] = heap_key[best];
                    heap_tag[pos] = heap_tag[best];
                    pos           = best;
                end
            end
            heap_key[pos] = mov_key;
            heap_tag[pos] = mov_tag;
        end
        res.count = CNT_WIDTH'(heap_count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_stim_row op_row(input bit cmd,
                                         input logic [KEY_WIDTH-1:0] key,
                                         input logic [TAG_WIDTH-1:0] tag);
        t_stim_row row;
        row        = '{default: '0};
        row.cmd    = cmd;
        row.key    = key;
        row.tag    = tag;
        return row;
    endfunction

    function automatic t_stim_row typed_row(input bit cmd,
                                            input logic [KEY_WIDTH-1:0] key,
                                            input logic [TAG_WIDTH-1:0] tag,
                                            input logic [KEY_WIDTH-1:0] pkey,
                                            input logic [TAG_WIDTH-1:0] ptag,
                                            input t_status status,
                                            input int count);
        t_stim_row row;
        row             = op_row(cmd, key, tag);
        row.typed       = 1'b1;
        row.want.key    = pkey;
        row.want.tag    = ptag;
        row.want.status = status;
        row.want.count  = CNT_WIDTH'(count);
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input bit value);
        t_stim_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.key    = KEY_WIDTH'(value);
        return row;
    endfunction

    // Keys lean on extremes, the sign boundary and a narrow band for ties.
    function automatic logic [KEY_WIDTH-1:0] rand_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(KEY_WIDTH-1){1'b0}}};
            3:       return {1'b0, {(KEY_WIDTH-1){1'b1}}};
            4, 5:    return KEY_WIDTH'($urandom_range(0, 15));
            6:       return KEY_WIDTH'($urandom_range(0, 15)) - KEY_WIDTH'(8);
            default: return KEY_WIDTH'($urandom);
        endcase
    endfunction

    // Presents one transaction, waits for the handshake, records the
    // expected result, then maybe idles before the next one.
    task automatic send_item(input bit cmd,
                             input logic [KEY_WIDTH-1:0] key,
                             input logic [TAG_WIDTH-1:0] tag,
                             input bit typed,
                             input t_heap_result want);
        t_heap_result predicted;
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_key     <= key;
        in_tag     <= tag;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = heap_apply(cmd, key, tag);
        pending_results.push_back(typed ? want : predicted);
        while (!long_burst && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // key_signed only changes with nothing in flight
    task automatic write_key_signed(input bit value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        heap_signed = value;
    endtask

    task automatic run_mixed(input int n_items, input int insert_pct);
        repeat (n_items) begin
            send_item(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                      rand_key(), TAG_WIDTH'($urandom), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: oldest expectation against each accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_heap_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_popped_key !== want.key) begin
                        $error("popped_key: expected %h, actual %h", want.key, o_popped_key);
                        error_count++;
                    end
                    if (o_popped_tag !== want.tag) begin
                        $error("popped_tag: expected %h, actual %h", want.tag, o_popped_tag);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.count, o_entry_count);
                        error_count++;
                    end
                end
            end
            out_ready <= long_burst || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_stim_row rows[$];
        int        guard;

        // Unsigned: empty remove, extremes, three equal keys to check that
        // ties keep their slots, drain, then empty again.
        rows.push_back(typed_row(CMD_REMOVE, '0, '0, '0, '0, HQ_EMPTY, 0));
        rows.push_back(typed_row(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, HQ_DONE, 1));
        rows.push_back(typed_row(CMD_INSERT, 32'h0000_0000, 16'h0000, '0, '0, HQ_DONE, 2));
        rows.push_back(op_row(CMD_INSERT, 32'h8000_0000, 16'h8000));
        rows.push_back(op_row(CMD_INSERT, 32'd5, 16'h0001));
        rows.push_back(op_row(CMD_INSERT, 32'd5, 16'h0002));
        rows.push_back(op_row(CMD_INSERT, 32'd5, 16'h0003));
        rows.push_back(typed_row(CMD_REMOVE, '1, '1, 32'h0, 16'h0, HQ_DONE, 5));
        repeat (5) rows.push_back(op_row(CMD_REMOVE, '1, '1));
        rows.push_back(typed_row(CMD_REMOVE, '0, '0, '0, '0, HQ_EMPTY, 0));
        // Signed: most negative key must come out first.
        rows.push_back(cfg_row(1'b1));
        rows.push_back(op_row(CMD_INSERT, 32'h7FFF_FFFF, 16'h00FF));
        rows.push_back(op_row(CMD_INSERT, 32'h8000_0000, 16'hFF00));
        rows.push_back(op_row(CMD_INSERT, 32'hFFFF_FFFF, 16'h5555));
        rows.push_back(op_row(CMD_INSERT, 32'h0000_0000, 16'hAAAA));
        rows.push_back(typed_row(CMD_REMOVE, '0, '0, 32'h8000_0000, 16'hFF00, HQ_DONE, 3));
        repeat (3) rows.push_back(op_row(CMD_REMOVE, '0, '0));
        rows.push_back(typed_row(CMD_REMOVE, '0, '0, '0, '0, HQ_EMPTY, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_key_signed(1'b0);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_key_signed(rows[i].key[0]);
            end else begin
                send_item(rows[i].cmd, rows[i].key, rows[i].tag, rows[i].typed, rows[i].want);
            end
        end

        // Random traffic; each register write drains the pipe first.
        write_key_signed(1'b0);
        run_mixed(200, 65);
        write_key_signed(1'b1);
        run_mixed(200, 45);

        // Back-to-back fill past full, then drain past empty.
        long_burst = 1'b1;
        while (heap_count < CAPACITY) begin
            send_item(CMD_INSERT, rand_key(), TAG_WIDTH'($urandom), 1'b0, '0);
        end
        repeat (4) send_item(CMD_INSERT, rand_key(), TAG_WIDTH'($urandom), 1'b0, '0);
        while (heap_count > 0) begin
            send_item(CMD_REMOVE, rand_key(), TAG_WIDTH'($urandom), 1'b0, '0);
        end
        repeat (3) send_item(CMD_REMOVE, rand_key(), TAG_WIDTH'($urandom), 1'b0, '0);
        long_burst = 1'b0;

        write_key_signed(1'b0);
        run_mixed(200, 60);
        write_key_signed(1'b1);
        run_mixed(180, 40);

        in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (pending_results.size() != 0) begin
                $error("%0d expected results never arrived", pending_results.size());
            end
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hmq_pkg.sv
hdl/hmq_dp.sv
hdl/hmq_ctrl.sv
hdl/binary_min_heap_queue.sv
dv/binary_min_heap_queue_tb.sv
